// ===== sv/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int BYTE_W      = 8;
   localparam int KEY_CNT_W   = 9;

   // action codes of an input beat
   localparam logic ACT_KEY  = 1'b0;
   localparam logic ACT_DATA = 1'b1;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
   } rsp_type;

   // key store read request from the permutation engine
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] idx;
   } key_rd_type;

endpackage

`default_nettype wire

// ===== sv/rc4_key_store.sv =====
// Key byte store with fill count and key-sequence tracking.
`timescale 1ns / 1ps
`default_nettype none

module rc4_key_store import rc4_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_go,
   input  wire req_type              req_data,
   input  wire key_rd_type           key_rd,
   output logic [BYTE_W-1:0]         key_rd_data,
   output logic [KEY_CNT_W-1:0]      key_count
);

   logic [BYTE_W-1:0]    key_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0]    rd_ff;
   logic [KEY_CNT_W-1:0] count_ff, count_in;
   logic                 loading_ff, loading_in;
   logic                 key_beat;
   logic                 store;
   logic [KEY_CNT_W-1:0] base;

   assign key_beat = req_go && (req_data.action == ACT_KEY);
   // a key beat outside a sequence starts a fresh key
   assign base     = loading_ff ? count_ff : '0;
   assign store    = key_beat && (base < KEY_CNT_W'(TABLE_DEPTH));

   always_comb begin
      count_in   = count_ff;
      loading_in = loading_ff;
      if (key_beat) begin
         count_in   = store ? base + 1'b1 : base;
         loading_in = !req_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         loading_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         loading_ff <= loading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         key_mem[base[BYTE_W-1:0]] <= req_data.value;
      end
      if (key_rd.en) begin
         rd_ff <= key_mem[key_rd.idx];
      end
   end

   assign key_rd_data = rd_ff;
   assign key_count   = count_ff;

endmodule

`default_nettype wire

// ===== sv/rc4_sbox_core.sv =====
// Permutation table memory with key schedule and keystream sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rc4_sbox_core import rc4_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_go,
   input  wire req_type              req_data,
   output logic                      idle,
   input  wire logic [KEY_CNT_W-1:0] key_count,
   output key_rd_type                key_rd,
   input  wire logic [BYTE_W-1:0]    key_rd_data,
   input  wire logic                 out_free,
   output logic                      res_load,
   output rsp_type                   res_data
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_INIT = 9'b000000010,
      ST_K0   = 9'b000000100,
      ST_K1   = 9'b000001000,
      ST_K2   = 9'b000010000,
      ST_K3   = 9'b000100000,
      ST_P1   = 9'b001000000,
      ST_P2   = 9'b010000000,
      ST_P3   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] perm_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] rd_ff;

   // i doubles as the sweep counter, j as the schedule accumulator
   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] kidx_ff, kidx_in;
   logic [BYTE_W-1:0] a_ff, a_in;
   logic [BYTE_W-1:0] b_ff, b_in;
   logic [BYTE_W-1:0] t_ff, t_in;
   logic [BYTE_W-1:0] val_ff, val_in;
   logic              last_ff, last_in;

   logic              we, re;
   logic [BYTE_W-1:0] wa, wd, ra;
   logic [BYTE_W-1:0] ksa_sum, j_step, t_sum, s_t;
   logic [KEY_CNT_W-1:0] kidx_inc;
   logic              kidx_wrap;

   assign ksa_sum   = j_ff + rd_ff + key_rd_data;
   assign j_step    = j_ff + rd_ff;
   assign t_sum     = a_ff + rd_ff;
   assign kidx_inc  = {1'b0, kidx_ff} + 1'b1;
   assign kidx_wrap = (kidx_inc >= key_count);

   // s[t] read overlaps the swap writes: take the swapped values directly
   always_comb begin
      if (t_ff == j_ff) begin
         s_t = a_ff;
      end else if (t_ff == i_ff) begin
         s_t = b_ff;
      end else begin
         s_t = rd_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      kidx_in    = kidx_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      t_in       = t_ff;
      val_in     = val_ff;
      last_in    = last_ff;
      we         = 1'b0;
      wa         = i_ff;
      wd         = i_ff;
      re         = 1'b0;
      ra         = i_ff;
      key_rd.en  = 1'b0;
      key_rd.idx = kidx_ff;
      res_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               if (req_data.action == ACT_KEY) begin
                  if (req_data.last) begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_INIT;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  re       = 1'b1;
                  ra       = i_ff + 1'b1;
                  val_in   = req_data.value;
                  last_in  = req_data.last;
                  state_in = ST_P1;
               end
            end
         end
         ST_INIT: begin
            we   = 1'b1;
            i_in = i_ff + 1'b1;
            if (i_ff == '1) begin
               kidx_in  = '0;
               j_in     = '0;
               state_in = ST_K0;
            end
         end
         ST_K0: begin
            re        = 1'b1;
            key_rd.en = 1'b1;
            state_in  = ST_K1;
         end
         ST_K1: begin
            a_in     = rd_ff;
            j_in     = ksa_sum;
            re       = 1'b1;
            ra       = ksa_sum;
            state_in = ST_K2;
         end
         ST_K2: begin
            we       = 1'b1;
            wd       = rd_ff;
            state_in = ST_K3;
         end
         ST_K3: begin
            we      = 1'b1;
            wa      = j_ff;
            wd      = a_ff;
            i_in    = i_ff + 1'b1;
            kidx_in = kidx_wrap ? '0 : kidx_inc[BYTE_W-1:0];
            if (i_ff == '1) begin
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         ST_P1: begin
            a_in     = rd_ff;
            j_in     = j_step;
            re       = 1'b1;
            ra       = j_step;
            state_in = ST_P2;
         end
         ST_P2: begin
            b_in     = rd_ff;
            we       = 1'b1;
            wd       = rd_ff;
            t_in     = t_sum;
            re       = 1'b1;
            ra       = t_sum;
            state_in = ST_P3;
         end
         ST_P3: begin
            // repeated while stalled; the write is idempotent
            we = 1'b1;
            wa = j_ff;
            wd = a_ff;
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      kidx_ff <= kidx_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      t_ff    <= t_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         perm_mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= perm_mem[ra];
      end
   end

   assign idle              = (state_ff == ST_IDLE);
   assign res_data.out_byte = val_ff ^ s_t;
   assign res_data.out_last = last_ff;

endmodule

`default_nettype wire

// ===== sv/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher: handshakes, result register, assertions.
//
//   channel   dir   handshake              beat
//   req_      in    req_valid/req_ready    req_type: action, value, last
//   rsp_      out   rsp_valid/rsp_ready    rsp_type: out_byte, out_last
//
// Key beat: taken whenever the engine is idle; one with last set starts the key
// schedule: an identity fill of the table, then 256 swap steps, each reading
// s[i] and the key byte, reading s[j], then writing s[i] and s[j] in turn
// through the single write port of the table memory.
// Data beat: the engine steps through read s[i], read s[j], swap writes with the
// s[t] read alongside and load result; the next beat is taken back in idle.
// Reset clears the sequencer, indices, key count and the result valid; the
// table and key memories hold nothing defined until written.
// A stalled result holds the engine in its last step and no beat is taken;
// once the engine is idle, beats are taken even while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic                 core_idle;
   logic                 req_go;
   logic                 out_free;
   logic                 res_load;
   rsp_type              res_data;
   key_rd_type           key_rd;
   logic [BYTE_W-1:0]    key_rd_data;
   logic [KEY_CNT_W-1:0] key_count;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   assign req_ready = core_idle;
   assign req_go    = req_valid && core_idle;
   // result register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;

   rc4_key_store u_key_store (
      .clock       (clock),
      .reset       (reset),
      .req_go      (req_go),
      .req_data    (req_data),
      .key_rd      (key_rd),
      .key_rd_data (key_rd_data),
      .key_count   (key_count)
   );

   rc4_sbox_core u_sbox_core (
      .clock       (clock),
      .reset       (reset),
      .req_go      (req_go),
      .req_data    (req_data),
      .idle        (core_idle),
      .key_count   (key_count),
      .key_rd      (key_rd),
      .key_rd_data (key_rd_data),
      .out_free    (out_free),
      .res_load    (res_load),
      .res_data    (res_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a data beat keeps the engine busy for the following cycle
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == ACT_DATA) |=> !req_ready)
      else $error("engine idle right after a data beat");

   // the final key byte starts the schedule
   a_sched_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == ACT_KEY) && req_data.last
      |=> !req_ready)
      else $error("schedule did not start on final key byte");

   // an ordinary key byte never blocks the input
   a_key_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == ACT_KEY) && !req_data.last
      |=> req_ready)
      else $error("input blocked after a plain key byte");

   // a result appears only as the engine returns to idle
   a_rsp_on_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && !$past(req_ready))
      else $error("result loaded outside the final data step");

endmodule

`default_nettype wire

// ===== dv/rc4_stream_cipher_test.sv =====
// Self-checking testbench for the RC4 stream cipher: directed, long-key, back-pressure, no-idle and random traffic.
`timescale 1ns / 1ps

module rc4_stream_cipher_test;
   import rc4_pkg::*;

   localparam int STALL_LIMIT  = 6000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES = 1400;  // covers a key schedule still in flight
   localparam int HOLD_OFF_LEN = 400;
   localparam int RANDOM_BEATS = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;

   rc4_stream_cipher u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cipher state as the block should hold it
   logic [BYTE_W-1:0] perm_s    [TABLE_DEPTH];
   logic [BYTE_W-1:0] key_bytes [TABLE_DEPTH];
   int                key_len   = 0;
   logic [BYTE_W-1:0] idx_i     = '0;
   logic [BYTE_W-1:0] idx_j     = '0;
   bit                key_open  = 1'b0;

   rsp_type cipher_out_q [$];
   rsp_type oldest_cipher;

   int  failures      = 0;
   int  beats_sent    = 0;
   int  key_beats     = 0;
   int  data_beats    = 0;
   int  schedules_run = 0;
   int  results_seen  = 0;
   int  stall_cycles  = 0;
   int  hold_off_left = 0;
   bit  hold_off_ask  = 1'b0;
   bit  no_idle       = 1'b0;

   // advance the cipher model by one accepted beat
   function automatic void apply_rc4_beat(req_type beat);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] held;
      logic [BYTE_W-1:0] t;
      if (beat.action == ACT_KEY) begin
         key_beats++;
         if (!key_open) begin
            key_len  = 0;
            key_open = 1'b1;
         end
         if (key_len < TABLE_DEPTH) begin
            key_bytes[key_len] = beat.value;
            key_len++;
         end
         if (beat.last) begin
            for (int n = 0; n < TABLE_DEPTH; n++) perm_s[n] = BYTE_W'(n);
            acc = '0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
               acc       = acc + perm_s[n] + key_bytes[n % key_len];
               held      = perm_s[n];
               perm_s[n] = perm_s[acc];
               perm_s[acc] = held;
            end
            idx_i    = '0;
            idx_j    = '0;
            key_open = 1'b0;
            schedules_run++;
         end
      end else begin
         data_beats++;
         idx_i         = idx_i + 8'd1;
         idx_j         = idx_j + perm_s[idx_i];
         held          = perm_s[idx_i];
         perm_s[idx_i] = perm_s[idx_j];
         perm_s[idx_j] = held;
         t             = perm_s[idx_i] + perm_s[idx_j];
         cipher_out_q.push_back('{out_byte: beat.value ^ perm_s[t], out_last: beat.last});
      end
   endfunction

   // offer one beat from a falling edge and hold it until taken; valid is left high
   task automatic send_beat(logic action, logic [BYTE_W-1:0] value, logic last);
      req_type beat;
      beat.action = action;
      beat.value  = value;
      beat.last   = last;
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      apply_rc4_beat(beat);
      beats_sent++;
   endtask

   task automatic send_key(int len);
      for (int k = 0; k < len; k++)
         send_beat(ACT_KEY, 8'($urandom_range(255)), k == len - 1);
   endtask

   task automatic send_message(int len);
      for (int k = 0; k < len; k++)
         send_beat(ACT_DATA, 8'($urandom_range(255)), k == len - 1);
   endtask

   // receiver: random ready, a counted hold-off on request, or always ready
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_ask) begin
         hold_off_ask  = 1'b0;
         hold_off_left = HOLD_OFF_LEN;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (cipher_out_q.size() == 0) begin
            $error("unexpected result beat: out_byte %02h out_last %0b",
                   rsp_data.out_byte, rsp_data.out_last);
            failures++;
         end else begin
            oldest_cipher = cipher_out_q.pop_front();
            if (rsp_data.out_byte !== oldest_cipher.out_byte) begin
               $error("out_byte: expected %02h, got %02h",
                      oldest_cipher.out_byte, rsp_data.out_byte);
               failures++;
            end
            if (rsp_data.out_last !== oldest_cipher.out_last) begin
               $error("out_last: expected %0b, got %0b",
                      oldest_cipher.out_last, rsp_data.out_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("FAIL rc4_stream_cipher");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // field extremes, both last values, data arriving mid-key, re-keying
   task automatic test_directed;
      send_beat(ACT_KEY,  8'hFF, 1'b1);
      send_beat(ACT_DATA, 8'h00, 1'b0);
      send_beat(ACT_DATA, 8'hFF, 1'b0);
      send_beat(ACT_DATA, 8'h80, 1'b1);
      send_beat(ACT_KEY,  8'h00, 1'b0);
      send_beat(ACT_KEY,  8'h80, 1'b0);
      send_beat(ACT_KEY,  8'hFF, 1'b1);
      send_beat(ACT_DATA, 8'hFF, 1'b0);
      send_beat(ACT_DATA, 8'h01, 1'b1);
      send_beat(ACT_KEY,  8'h11, 1'b0);
      send_beat(ACT_DATA, 8'hAA, 1'b0);
      send_beat(ACT_DATA, 8'h55, 1'b1);
      send_beat(ACT_KEY,  8'h22, 1'b1);
      send_beat(ACT_DATA, 8'h00, 1'b1);
      send_beat(ACT_KEY,  8'h00, 1'b1);
      send_beat(ACT_DATA, 8'h7F, 1'b0);
      send_beat(ACT_DATA, 8'hFE, 1'b1);
   endtask

   // key of exactly full store size, then one past it where the tail is dropped
   task automatic test_long_keys;
      send_key(TABLE_DEPTH);
      send_message(12);
      send_key(TABLE_DEPTH + 1);
      send_message(12);
   endtask

   // receiver stalls for a long stretch while data keeps coming
   task automatic test_back_pressure;
      hold_off_ask = 1'b1;
      send_message(40);
   endtask

   task automatic test_no_idle_stretch;
      no_idle = 1'b1;
      send_key($urandom_range(1, 16));
      send_message(60);
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic;
      int pick;
      int klen;
      int cut;
      int stop_at;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            klen = $urandom_range(1, 16);
            send_key(klen);
            send_message($urandom_range(1, 24));
         end else if (pick < 21) begin
            // pending key interrupted by data, then completed
            klen = $urandom_range(2, 8);
            cut  = $urandom_range(1, klen - 1);
            for (int k = 0; k < cut; k++)
               send_beat(ACT_KEY, 8'($urandom_range(255)), 1'b0);
            repeat ($urandom_range(1, 4))
               send_beat(ACT_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
            for (int k = cut; k < klen; k++)
               send_beat(ACT_KEY, 8'($urandom_range(255)), k == klen - 1);
         end else if (pick < 26) begin
            repeat ($urandom_range(1, 6))
               send_beat(ACT_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            send_message($urandom_range(1, 24));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_keys();
      test_back_pressure();
      test_no_idle_stretch();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d beats in (%0d key, %0d data), %0d key schedules, %0d results checked",
               beats_sent, key_beats, data_beats, schedules_run, results_seen);
      $display("covered mid-key data, keys of 1 to %0d bytes and a %0d-cycle output stall",
               TABLE_DEPTH + 1, HOLD_OFF_LEN);
      if (failures == 0) begin
         $display("PASS rc4_stream_cipher");
      end else begin
         $display("FAIL rc4_stream_cipher");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/rc4_pkg.sv
sv/rc4_key_store.sv
sv/rc4_sbox_core.sv
sv/rc4_stream_cipher.sv
dv/rc4_stream_cipher_test.sv
